[hdl/assert_macros.svh]
// Assertion macros shared by the encoder counter RTL.
// Expects signals named clk and rst_n in the including scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge outside reset
`define ERC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition is followed by another in the next cycle
`define ERC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/erc_pkg.sv]
// Shared types and constants for the encoder relative count block.
// No dependencies; imported by every module of the block.
`default_nettype none

package erc_pkg;

    // Gain after reset: 1.0 in signed Q16.16
    localparam logic signed [31:0] GAIN_RESET = 32'sh0001_0000;

    typedef struct packed {
        logic               operational;
        logic signed [31:0] enc_count;
        logic [31:0]        enc_period;
        logic               preset_done;
        logic [3:0]         input_status;
        logic               index_level;
        logic               index_arm_set;
        logic               count_reset;
        logic               preset_request;
    } sample_t;

    typedef struct packed {
        logic signed [31:0] held_raw_count;
        logic [31:0]        held_raw_period;
        logic signed [31:0] relative_count;
        logic signed [63:0] position;
        logic [3:0]         status_out;
        logic               preset_command;
        logic               index_armed;
    } result_t;

    // Stage-to-stage transaction before scaling
    typedef struct packed {
        logic signed [31:0] held_raw_count;
        logic [31:0]        held_raw_period;
        logic signed [31:0] relative_count;
        logic [3:0]         status_out;
        logic               preset_command;
        logic               index_armed;
    } count_t;

    // Stage control: take loads the stage, drain empties it
    typedef struct packed {
        logic take;
        logic drain;
    } pipe_ctrl_t;

endpackage

`default_nettype wire

[hdl/erc_update.sv]
// Count update stage: channel state and the count register stage.
// Depends on erc_pkg.
`default_nettype none

module erc_update (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire erc_pkg::pipe_ctrl_t ctrl,
    input  wire erc_pkg::sample_t item,
    output logic                  mid_valid,
    output erc_pkg::count_t       mid_data
);
    import erc_pkg::*;

    logic [31:0] last_raw_reg;
    logic [31:0] rel_count_reg;
    logic        prev_index_reg;
    logic        first_pass_reg;
    logic        was_op_reg;
    logic        pending_reg;
    logic        arm_reg;
    logic [31:0] hold_count_reg;
    logic [31:0] hold_period_reg;
    logic        mid_valid_reg;
    count_t      mid_reg;

    logic        pending_latched;
    logic        arm_latched;
    logic        pending_next;
    logic        arm_next;
    logic        zero_req;
    logic        index_hit;
    logic        rebase;
    logic [31:0] delta;
    logic [31:0] rel_count_next;
    logic [31:0] hold_count_next;
    logic [31:0] hold_period_next;

    // Work out the update for the item in the input register
    always_comb
    begin
        pending_latched  = pending_reg | item.preset_request;
        arm_latched      = arm_reg | item.index_arm_set;
        pending_next     = item.preset_done ? 1'b0 : pending_latched;
        zero_req         = first_pass_reg | item.count_reset;
        index_hit        = item.index_level & ~prev_index_reg & ~zero_req & arm_latched;
        arm_next         = index_hit ? 1'b0 : arm_latched;
        rebase           = ~was_op_reg | item.preset_done | zero_req | index_hit;
        delta            = rebase ? 32'd0 : (item.enc_count - last_raw_reg);
        rel_count_next   = (zero_req | index_hit) ? 32'd0 : (rel_count_reg + delta);
        hold_count_next  = pending_next ? hold_count_reg : item.enc_count;
        hold_period_next = pending_next ? hold_period_reg : item.enc_period;
    end

    // Advance channel state on each processed transaction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_raw_reg    <= '0;
            rel_count_reg   <= '0;
            prev_index_reg  <= 1'b0;
            first_pass_reg  <= 1'b1;
            was_op_reg      <= 1'b0;
            pending_reg     <= 1'b0;
            arm_reg         <= 1'b0;
            hold_count_reg  <= '0;
            hold_period_reg <= '0;
        end
        else if (ctrl.take)
        begin
            if (item.operational)
            begin
                last_raw_reg    <= item.enc_count;
                rel_count_reg   <= rel_count_next;
                prev_index_reg  <= item.index_level;
                first_pass_reg  <= 1'b0;
                was_op_reg      <= 1'b1;
                pending_reg     <= pending_next;
                arm_reg         <= arm_next;
                hold_count_reg  <= hold_count_next;
                hold_period_reg <= hold_period_next;
            end
            else
            begin
                was_op_reg  <= 1'b0;
                pending_reg <= pending_latched;
                arm_reg     <= arm_latched;
            end
        end
    end

    // Hold the stage valid until the scale stage takes it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mid_valid_reg <= 1'b0;
        else if (ctrl.take && item.operational)
            mid_valid_reg <= 1'b1;
        else if (ctrl.drain)
            mid_valid_reg <= 1'b0;
    end

    // Load the count transaction; drop non-operational items
    always_ff @(posedge clk)
    begin
        if (ctrl.take && item.operational)
        begin
            mid_reg.held_raw_count  <= hold_count_next;
            mid_reg.held_raw_period <= hold_period_next;
            mid_reg.relative_count  <= rel_count_next;
            mid_reg.status_out      <= item.input_status;
            mid_reg.preset_command  <= pending_next;
            mid_reg.index_armed     <= arm_next;
        end
    end

    assign mid_valid = mid_valid_reg;
    assign mid_data  = mid_reg;

endmodule

`default_nettype wire

[hdl/erc_scale.sv]
// Scale stage: count times Q16.16 gain into the result register.
// Depends on erc_pkg.
`default_nettype none

module erc_scale (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire erc_pkg::pipe_ctrl_t ctrl,
    input  wire erc_pkg::count_t    mid_data,
    input  wire logic signed [31:0] gain,
    output logic                    out_valid,
    output erc_pkg::result_t        out_data
);
    import erc_pkg::*;

    logic        out_valid_reg;
    result_t     out_reg;
    logic signed [63:0] product;

    // Full signed product, exact in 64 bits
    assign product = $signed(mid_data.relative_count) * $signed(gain);

    // Hold result valid until the consumer takes it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (ctrl.take)
            out_valid_reg <= 1'b1;
        else if (ctrl.drain)
            out_valid_reg <= 1'b0;
    end

    // Load the result transaction
    always_ff @(posedge clk)
    begin
        if (ctrl.take)
        begin
            out_reg.held_raw_count  <= mid_data.held_raw_count;
            out_reg.held_raw_period <= mid_data.held_raw_period;
            out_reg.relative_count  <= mid_data.relative_count;
            out_reg.position        <= product;
            out_reg.status_out      <= mid_data.status_out;
            out_reg.preset_command  <= mid_data.preset_command;
            out_reg.index_armed     <= mid_data.index_armed;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

`default_nettype wire

[hdl/encoder_relative_count_index_latch_core.sv]
// Encoder channel relative count with index latch, top level.
// Depends on erc_pkg, erc_update, erc_scale and assert_macros.svh.
//
//  channel   handshake                  payload
//  sample    sample_valid/sample_stall  sample (sample_t)
//  result    result_valid/result_stall  result (result_t)
//  config    cfg_valid/cfg_ready        cfg_data (position gain, Q16.16)
//
// One sample per cycle sustained while result_stall is low; a result passes
// through the input register, the count update and the gain multiply stages
// before it can leave.
// The count update state loop closes within the stage, which sets the rate.
// Non-operational samples update the request latches and give no result.
// Reset clears the channel state and sets the gain to 1.0; a result stall
// backs up through the stages and raises sample_stall once all are full.
`default_nettype none

module encoder_relative_count_index_latch_core (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               sample_valid,
    output logic                    sample_stall,
    input  wire erc_pkg::sample_t   sample,
    output logic                    result_valid,
    input  wire logic               result_stall,
    output erc_pkg::result_t        result,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic signed [31:0] cfg_data
);
    import erc_pkg::*;

    `include "assert_macros.svh"

    logic               gain_wr;
    logic signed [31:0] position_gain_reg;
    logic               in_valid_reg;
    sample_t            in_data_reg;
    logic               mid_valid;
    count_t             mid_data;
    logic               out_free;
    logic               mid_free;
    logic               in_free;
    logic               accept;
    pipe_ctrl_t         update_ctrl;
    pipe_ctrl_t         scale_ctrl;
    logic               pipe_full;
    logic               op_take;
    logic               tail_empty;

    // Stage flow control
    assign out_free     = !result_valid || !result_stall;
    assign mid_free     = !mid_valid || out_free;
    assign in_free      = !in_valid_reg || mid_free;
    assign accept       = sample_valid && in_free;
    assign sample_stall = !in_free;

    assign update_ctrl.take  = in_valid_reg && mid_free;
    assign update_ctrl.drain = mid_valid && out_free;
    assign scale_ctrl.take   = mid_valid && out_free;
    assign scale_ctrl.drain  = result_valid && !result_stall;

    // Take gain writes at any time
    assign cfg_ready = 1'b1;
    assign gain_wr   = cfg_valid && cfg_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            position_gain_reg <= GAIN_RESET;
        else if (gain_wr)
            position_gain_reg <= cfg_data;
    end

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (accept)
            in_valid_reg <= 1'b1;
        else if (update_ctrl.take)
            in_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            in_data_reg <= sample;
    end

    erc_update u_update (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (update_ctrl),
        .item      (in_data_reg),
        .mid_valid (mid_valid),
        .mid_data  (mid_data)
    );

    erc_scale u_scale (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (scale_ctrl),
        .mid_data  (mid_data),
        .gain      (position_gain_reg),
        .out_valid (result_valid),
        .out_data  (result)
    );

    // Terms for the checks below
    assign pipe_full  = in_valid_reg && mid_valid && result_valid && result_stall;
    assign op_take    = update_ctrl.take && in_data_reg.operational;
    assign tail_empty = !result_valid && !mid_valid;

    // Stall only when every stage holds a transaction and the output waits
    `ERC_ASSERT(a_stall_full, !sample_stall || pipe_full, "sample_stall with a free stage")

    // An operational item always reaches the count stage
    `ERC_ASSERT_NEXT(a_op_loads, op_take, mid_valid, "operational item lost")

    // A new result comes only from the count stage
    `ERC_ASSERT_NEXT(a_result_source, tail_empty, !result_valid, "result with no count stage")

endmodule

`default_nettype wire
